@@ src/br1prd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// br1prd_pkg: shared types and constants of the ByteRun1 planar row decoder
// Transaction payloads, configuration register indexes, reset values, decode
// phase codes, status codes and parameter defaults.
// ----------------------------------------------------------------------------
package br1prd_pkg;

    // Parameter defaults
    localparam int unsigned DEF_LANE_BYTES    = 8;
    localparam int unsigned DEF_MAX_ROW_BYTES = 8192;
    localparam int unsigned DEF_MAX_PLANES    = 8;

    // Result items one repeat run may produce
    localparam int unsigned MAX_RESULTS = 16;
    localparam int unsigned K_W         = $clog2(MAX_RESULTS);

    // Field widths
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned ROWB_W     = 14;
    localparam int unsigned ROWC_W     = 16;
    localparam int unsigned PLC_W      = 4;
    localparam int unsigned PLANE_W    = 3;
    localparam int unsigned OFF_W      = 13;
    localparam int unsigned RUN_W      = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE        = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT = 4'd3;

    // Configuration reset values
    localparam logic [1:0]        RST_MODE        = 2'd1;
    localparam logic [ROWB_W-1:0] RST_ROW_BYTES   = 14'd40;
    localparam logic [ROWC_W-1:0] RST_ROW_COUNT   = 16'd200;
    localparam logic [PLC_W-1:0]  RST_PLANE_COUNT = 4'd5;

    // Compression modes
    localparam logic [1:0] MODE_RAW      = 2'd0;
    localparam logic [1:0] MODE_BYTERUN1 = 2'd1;

    // Decode phases
    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_LITERAL = 2'd1;
    localparam logic [1:0] PH_REPEAT  = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_MODE = 2'd1;
    localparam logic [1:0] ST_OVERRUN  = 2'd2;
    localparam logic [1:0] ST_DONE     = 2'd3;

    // Header byte that does nothing
    localparam logic [7:0] HDR_NOP = 8'd128;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       frame_start;
    } in_item_t;

    typedef struct packed {
        logic [63:0]        out_bytes;
        logic [3:0]         byte_count;
        logic [PLANE_W-1:0] plane_index;
        logic [15:0]        row_index;
        logic [OFF_W-1:0]   row_offset;
        logic [1:0]         status;
        logic               image_done;
        logic               last;
    } out_item_t;

endpackage
`default_nettype wire

@@ src/byterun1_planar_row_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byterun1_planar_row_decoder: ByteRun1 / raw planar row body decoder
// Decodes an image body byte stream into tagged groups of up to eight bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one body byte per
//   transaction; frame_start restarts position, run state and error.
//   Output channel (out_valid / out_stall / out_data) delivers result items
//   from a single output register; last marks the final item of a byte.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes
//   mode, row bytes, row count and plane count; ready is always high.
// Throughput: every byte but a repeat value that starts a run gives one
//   item, put in the output register on acceptance; such bytes go at one
//   per cycle while not stalled. A repeat value is set up first, then
//   gives one item per cycle while not stalled, ceil(run / LANE_BYTES)
//   items (at most 16), made by one shared lane fill unit and one shared
//   position advance unit; input stalls meanwhile.
// Reset clears position, run state and errors and loads register defaults.
// While the receiver stalls, the held item stays put and input is stalled.
// ----------------------------------------------------------------------------
module byterun1_planar_row_decoder
    import br1prd_pkg::*;
#(
    parameter int unsigned LANE_BYTES    = DEF_LANE_BYTES,
    parameter int unsigned MAX_ROW_BYTES = DEF_MAX_ROW_BYTES,
    parameter int unsigned MAX_PLANES    = DEF_MAX_PLANES
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_item_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_item_t                  out_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    localparam logic [3:0]        LANE_N  = 4'(LANE_BYTES);
    localparam logic [ROWB_W-1:0] RB_MAX  = ROWB_W'(MAX_ROW_BYTES);
    localparam logic [PLC_W-1:0]  PL_MAX  = PLC_W'(MAX_PLANES);
    localparam logic [K_W-1:0]    K_LAST  = K_W'(MAX_RESULTS - 1);

    // Configuration registers
    logic [1:0]        mode_reg;
    logic [ROWB_W-1:0] row_bytes_reg;
    logic [ROWC_W-1:0] row_count_reg;
    logic [PLC_W-1:0]  plane_count_reg;

    // Decode state
    logic               state_reg, state_next;
    logic [1:0]         phase_reg, phase_next;
    logic [RUN_W-1:0]   run_reg, run_next;
    logic [ROWB_W-1:0]  row_left_reg, row_left_next;
    logic [PLANE_W-1:0] plane_reg, plane_next;
    logic [15:0]        row_reg, row_next;
    logic [1:0]         sticky_reg, sticky_next;
    logic               done_reg, done_next;

    // Repeat run sequencer
    logic [7:0]         rep_byte_reg, rep_byte_next;
    logic [RUN_W-1:0]   rep_count_reg, rep_count_next;
    logic [RUN_W-1:0]   produced_reg, produced_next;
    logic [K_W-1:0]     k_reg, k_next;
    logic [OFF_W-1:0]   off_base_reg, off_base_next;

    // Output register
    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg, out_data_next;

    logic out_free;
    logic in_accept;

    // Effective configuration
    logic [ROWB_W-1:0] eff_rb;
    logic [PLC_W-1:0]  eff_planes;
    logic [ROWC_W-1:0] eff_rows;

    // State after the optional frame restart
    logic [1:0]         ph_c;
    logic [RUN_W-1:0]   run_c;
    logic [ROWB_W-1:0]  rl_c;
    logic [PLANE_W-1:0] pl_c;
    logic [15:0]        rw_c;
    logic [1:0]         st_c;
    logic               dn_c;
    logic [ROWB_W-1:0]  rl_fix;
    logic [OFF_W-1:0]   off_now;

    // Shared position advance unit
    logic [RUN_W-1:0]   adv_n;
    logic [ROWB_W-1:0]  adv_rl;
    logic [PLANE_W-1:0] adv_pl;
    logic [15:0]        adv_rw;
    logic [ROWB_W-1:0]  adv_rl_new;
    logic [PLANE_W-1:0] adv_pl_new;
    logic [15:0]        adv_rw_new;
    logic               adv_done;

    // Header decode
    logic [8:0]       hdr_count9;
    logic [RUN_W-1:0] hdr_count;
    logic [RUN_W-1:0] rep_cnt_in;

    // Run chunk
    logic [RUN_W-1:0] remaining;
    logic [3:0]       chunk_n;
    logic             chunk_last;

    out_item_t res;
    logic      res_load;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == S_IDLE) && out_free);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= RST_MODE;
            row_bytes_reg   <= RST_ROW_BYTES;
            row_count_reg   <= RST_ROW_COUNT;
            plane_count_reg <= RST_PLANE_COUNT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MODE:        mode_reg        <= cfg_data[1:0];
                REG_ROW_BYTES:   row_bytes_reg   <= cfg_data[ROWB_W-1:0];
                REG_ROW_COUNT:   row_count_reg   <= cfg_data[ROWC_W-1:0];
                REG_PLANE_COUNT: plane_count_reg <= cfg_data[PLC_W-1:0];
                default:         ;
            endcase
        end
    end

    // Clamped configuration
    always_comb
    begin
        if (row_bytes_reg == '0)
            eff_rb = ROWB_W'(1);
        else if (row_bytes_reg > RB_MAX)
            eff_rb = RB_MAX;
        else
            eff_rb = row_bytes_reg;

        if (plane_count_reg == '0)
            eff_planes = PLC_W'(1);
        else if (plane_count_reg > PL_MAX)
            eff_planes = PL_MAX;
        else
            eff_planes = plane_count_reg;

        eff_rows = (row_count_reg == '0) ? ROWC_W'(1) : row_count_reg;
    end

    // Frame restart and row position fix-up
    always_comb
    begin
        ph_c  = in_data.frame_start ? PH_HEADER : phase_reg;
        run_c = in_data.frame_start ? '0 : run_reg;
        rl_c  = in_data.frame_start ? '0 : row_left_reg;
        pl_c  = in_data.frame_start ? '0 : plane_reg;
        rw_c  = in_data.frame_start ? '0 : row_reg;
        st_c  = in_data.frame_start ? ST_OK : sticky_reg;
        dn_c  = in_data.frame_start ? 1'b0 : done_reg;
        rl_fix  = (rl_c == '0 || rl_c > eff_rb) ? eff_rb : rl_c;
        off_now = OFF_W'(eff_rb - rl_fix);
    end

    // Header byte to run length
    always_comb
    begin
        if (in_data.in_byte < HDR_NOP)
            hdr_count9 = {1'b0, in_data.in_byte} + 9'd1;
        else
            hdr_count9 = 9'd257 - {1'b0, in_data.in_byte};
        hdr_count  = hdr_count9[RUN_W-1:0];
        rep_cnt_in = (run_c == '0) ? RUN_W'(1) : run_c;
    end

    // Advance operand select: repeat run end or a single byte
    always_comb
    begin
        if (state_reg == S_RUN)
        begin
            adv_n  = rep_count_reg;
            adv_rl = row_left_reg;
            adv_pl = plane_reg;
            adv_rw = row_reg;
        end
        else
        begin
            adv_n  = RUN_W'(1);
            adv_rl = rl_fix;
            adv_pl = pl_c;
            adv_rw = rw_c;
        end
    end

    // Shared advance unit: consume bytes, step plane, row and completion
    always_comb
    begin
        adv_pl_new = adv_pl;
        adv_rw_new = adv_rw;
        adv_done   = 1'b0;
        if (ROWB_W'(adv_n) >= adv_rl)
            adv_rl_new = '0;
        else
            adv_rl_new = adv_rl - ROWB_W'(adv_n);
        if (adv_rl_new == '0)
        begin
            if ({1'b0, adv_pl} + PLC_W'(1) < eff_planes)
                adv_pl_new = adv_pl + PLANE_W'(1);
            else
            begin
                adv_pl_new = '0;
                if ({1'b0, adv_rw} + 17'd1 < {1'b0, eff_rows})
                    adv_rw_new = adv_rw + 16'd1;
                else
                begin
                    adv_rw_new = '0;
                    adv_done   = 1'b1;
                end
            end
        end
    end

    // Run chunk size
    always_comb
    begin
        remaining  = rep_count_reg - produced_reg;
        chunk_n    = (remaining > RUN_W'(LANE_N)) ? LANE_N : remaining[3:0];
        chunk_last = (remaining <= RUN_W'(LANE_N)) || (k_reg == K_LAST);
    end

    // Sequencer and result formation
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        run_next       = run_reg;
        row_left_next  = row_left_reg;
        plane_next     = plane_reg;
        row_next       = row_reg;
        sticky_next    = sticky_reg;
        done_next      = done_reg;
        rep_byte_next  = rep_byte_reg;
        rep_count_next = rep_count_reg;
        produced_next  = produced_reg;
        k_next         = k_reg;
        off_base_next  = off_base_reg;
        res            = '0;
        res_load       = 1'b0;

        if (in_accept)
        begin
            phase_next    = ph_c;
            run_next      = run_c;
            row_left_next = rl_c;
            plane_next    = pl_c;
            row_next      = rw_c;
            sticky_next   = st_c;
            done_next     = dn_c;
            res.last      = 1'b1;
            res_load      = 1'b1;
            if (st_c != ST_OK)
                res.status = st_c;
            else if (dn_c)
                res.status = ST_DONE;
            else if (mode_reg > MODE_BYTERUN1)
            begin
                sticky_next = ST_BAD_MODE;
                res.status  = ST_BAD_MODE;
            end
            else
            begin
                row_left_next   = rl_fix;
                res.plane_index = pl_c;
                res.row_index   = rw_c;
                res.row_offset  = off_now;
                if (mode_reg == MODE_RAW || ph_c == PH_LITERAL)
                begin
                    // One data byte, then step the position by one
                    if (mode_reg == MODE_RAW || run_c <= RUN_W'(1))
                    begin
                        phase_next = PH_HEADER;
                        run_next   = '0;
                    end
                    else
                        run_next = run_c - RUN_W'(1);
                    res.out_bytes  = {56'd0, in_data.in_byte};
                    res.byte_count = 4'd1;
                    res.image_done = adv_done;
                    row_left_next  = adv_rl_new;
                    plane_next     = adv_pl_new;
                    row_next       = adv_rw_new;
                    done_next      = adv_done;
                end
                else if (ph_c == PH_REPEAT)
                begin
                    phase_next = PH_HEADER;
                    run_next   = '0;
                    if (ROWB_W'(rep_cnt_in) > rl_fix)
                    begin
                        sticky_next     = ST_OVERRUN;
                        res             = '0;
                        res.last        = 1'b1;
                        res.status      = ST_OVERRUN;
                    end
                    else
                    begin
                        // Hand the run to the chunk sequencer
                        res_load       = 1'b0;
                        state_next     = S_RUN;
                        rep_byte_next  = in_data.in_byte;
                        rep_count_next = rep_cnt_in;
                        produced_next  = '0;
                        k_next         = '0;
                        off_base_next  = off_now;
                    end
                end
                else
                begin
                    // Header byte
                    phase_next = PH_HEADER;
                    run_next   = '0;
                    if (in_data.in_byte != HDR_NOP)
                    begin
                        if (ROWB_W'(hdr_count) > rl_fix)
                        begin
                            sticky_next = ST_OVERRUN;
                            res         = '0;
                            res.last    = 1'b1;
                            res.status  = ST_OVERRUN;
                        end
                        else
                        begin
                            phase_next = (in_data.in_byte < HDR_NOP) ? PH_LITERAL : PH_REPEAT;
                            run_next   = hdr_count;
                        end
                    end
                end
            end
        end
        else if (state_reg == S_RUN && out_free)
        begin
            // One chunk of the repeat run per cycle while the output is free
            res_load        = 1'b1;
            res.byte_count  = chunk_n;
            res.plane_index = plane_reg;
            res.row_index   = row_reg;
            res.row_offset  = off_base_reg + OFF_W'(produced_reg);
            for (int i = 0; i < 8; i++)
            begin
                res.out_bytes[i*8 +: 8] = (4'(i) < chunk_n) ? rep_byte_reg : 8'h00;
            end
            produced_next = produced_reg + RUN_W'(chunk_n);
            k_next        = k_reg + K_W'(1);
            if (chunk_last)
            begin
                res.last       = 1'b1;
                res.image_done = adv_done;
                row_left_next  = adv_rl_new;
                plane_next     = adv_pl_new;
                row_next       = adv_rw_new;
                done_next      = done_reg | adv_done;
                state_next     = S_IDLE;
            end
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_HEADER;
            run_reg       <= '0;
            row_left_reg  <= '0;
            plane_reg     <= '0;
            row_reg       <= '0;
            sticky_reg    <= ST_OK;
            done_reg      <= 1'b0;
            produced_reg  <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            run_reg       <= run_next;
            row_left_reg  <= row_left_next;
            plane_reg     <= plane_next;
            row_reg       <= row_next;
            sticky_reg    <= sticky_next;
            done_reg      <= done_next;
            produced_reg  <= produced_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rep_byte_reg  <= rep_byte_next;
        rep_count_reg <= rep_count_next;
        off_base_reg  <= off_base_next;
        out_data_reg  <= out_data_next;
    end

endmodule
`default_nettype wire
